// File: rtl/nlcp_pkg.sv
// shared types and constants for the numeric literal classifier
`timescale 1ns / 1ps

package nlcp_pkg;

  // default width of the internal value accumulators
  localparam int VALUE_WIDTH_DEF = 32;
  // width of the value field on the result channel
  localparam int RESULT_WIDTH = 32;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG1  = 8'h31;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_B_UP  = 8'h42;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // result class codes
  typedef enum logic [2:0] {
    CL_INVALID = 3'd0,
    CL_HEX     = 3'd1,
    CL_INT     = 3'd2,
    CL_REAL    = 3'd3,
    CL_BIN     = 3'd4
  } class_t;

  // main scanner phase
  typedef enum logic [9:0] {
    PH_START = 10'b00_0000_0001,
    PH_ZERO  = 10'b00_0000_0010,
    PH_INT   = 10'b00_0000_0100,
    PH_HEX0  = 10'b00_0000_1000,
    PH_HEX   = 10'b00_0001_0000,
    PH_FRAC  = 10'b00_0010_0000,
    PH_EXP0  = 10'b00_0100_0000,
    PH_EXP   = 10'b00_1000_0000,
    PH_DONE  = 10'b01_0000_0000,
    PH_ENDED = 10'b10_0000_0000
  } scan_phase_t;

  // binary literal tracker
  typedef enum logic [3:0] {
    BP_START  = 4'b0001,
    BP_DIGITS = 4'b0010,
    BP_YES    = 4'b0100,
    BP_FAIL   = 4'b1000
  } bin_phase_t;

  // decimal value parser
  typedef enum logic [3:0] {
    DP_WS     = 4'b0001,
    DP_SIGN   = 4'b0010,
    DP_DIGITS = 4'b0100,
    DP_STOP   = 4'b1000
  } dec_phase_t;

  // scanner phase together with the class it decided
  typedef struct packed {
    scan_phase_t phase;
    class_t      cls;
  } scan_state_t;

  // result handed from the scanner to the output buffer
  typedef struct packed {
    class_t                    number_class;
    logic                      value_valid;
    logic [RESULT_WIDTH-1:0]   value;
  } scan_result_t;

endpackage

// File: rtl/nlcp_text_if.sv
// channel that carries the text bytes into the classifier
`timescale 1ns / 1ps

interface nlcp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

// File: rtl/nlcp_result_if.sv
// channel that carries one classification result per text
`timescale 1ns / 1ps

interface nlcp_result_if;
  logic                                    valid;
  logic                                    ready;
  logic [2:0]                              number_class;
  logic                                    value_valid;
  logic signed [nlcp_pkg::RESULT_WIDTH-1:0] value;

  modport source (output valid, output number_class, output value_valid, output value,
                  input ready);
  modport sink (input valid, input number_class, input value_valid, input value,
                output ready);
endinterface

// File: rtl/nlcp_scan.sv
// scanner state, accumulators and per-byte classification logic
`timescale 1ns / 1ps

module nlcp_scan #(
  parameter int VALUE_WIDTH = nlcp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             ch,
  input  logic                   last,
  output nlcp_pkg::scan_result_t result
);

  // character helpers
  function automatic logic is_dec(input logic [7:0] c);
    return (c >= nlcp_pkg::CH_DIG0) && (c <= nlcp_pkg::CH_DIG9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) ||
           ((c >= nlcp_pkg::CH_A_LO) && (c <= nlcp_pkg::CH_F_LO)) ||
           ((c >= nlcp_pkg::CH_A_UP) && (c <= nlcp_pkg::CH_F_UP));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return is_dec(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  // main scanner: one byte, phase and class only
  function automatic nlcp_pkg::scan_state_t scan_step(input nlcp_pkg::scan_state_t s,
                                                     input logic [7:0] c);
    nlcp_pkg::scan_state_t r;
    nlcp_pkg::scan_phase_t eff;
    logic term;
    logic stop;
    r    = s;
    eff  = s.phase;
    term = (c == nlcp_pkg::CH_NUL) || (c == nlcp_pkg::CH_SPACE);
    stop = 1'b0;
    if (s.phase == nlcp_pkg::PH_START) begin
      if (c == nlcp_pkg::CH_MINUS) begin
        r.phase = nlcp_pkg::PH_INT;
        stop    = 1'b1;
      end else if (c == nlcp_pkg::CH_DIG0) begin
        r.phase = nlcp_pkg::PH_ZERO;
        stop    = 1'b1;
      end else begin
        eff = nlcp_pkg::PH_INT;
      end
    end else if (s.phase == nlcp_pkg::PH_ZERO) begin
      if (c == nlcp_pkg::CH_X_LO || c == nlcp_pkg::CH_X_UP) begin
        r.phase = nlcp_pkg::PH_HEX0;
        stop    = 1'b1;
      end else begin
        eff = nlcp_pkg::PH_INT;
      end
    end
    if (!stop) begin
      unique case (eff)
        nlcp_pkg::PH_INT: begin
          if (is_dec(c)) begin
            r.phase = nlcp_pkg::PH_INT;
          end else if (c == nlcp_pkg::CH_DOT) begin
            r.phase = nlcp_pkg::PH_FRAC;
          end else if (c == nlcp_pkg::CH_E_LO) begin
            r.phase = nlcp_pkg::PH_EXP0;
          end else begin
            r.phase = nlcp_pkg::PH_DONE;
            r.cls   = term ? nlcp_pkg::CL_INT : nlcp_pkg::CL_INVALID;
          end
        end
        nlcp_pkg::PH_HEX0, nlcp_pkg::PH_HEX: begin
          if (is_hex(c)) begin
            r.phase = nlcp_pkg::PH_HEX;
          end else begin
            r.phase = nlcp_pkg::PH_DONE;
            r.cls   = (eff == nlcp_pkg::PH_HEX && term) ? nlcp_pkg::CL_HEX
                                                       : nlcp_pkg::CL_INVALID;
          end
        end
        nlcp_pkg::PH_FRAC: begin
          if (is_dec(c)) begin
            r.phase = nlcp_pkg::PH_FRAC;
          end else if (c == nlcp_pkg::CH_E_LO) begin
            r.phase = nlcp_pkg::PH_EXP0;
          end else begin
            r.phase = nlcp_pkg::PH_DONE;
            r.cls   = term ? nlcp_pkg::CL_REAL : nlcp_pkg::CL_INVALID;
          end
        end
        nlcp_pkg::PH_EXP0: begin
          if (c == nlcp_pkg::CH_PLUS || c == nlcp_pkg::CH_MINUS || is_dec(c)) begin
            r.phase = nlcp_pkg::PH_EXP;
          end else begin
            r.phase = nlcp_pkg::PH_DONE;
            r.cls   = term ? nlcp_pkg::CL_REAL : nlcp_pkg::CL_INVALID;
          end
        end
        nlcp_pkg::PH_EXP: begin
          if (is_dec(c)) begin
            r.phase = nlcp_pkg::PH_EXP;
          end else begin
            r.phase = nlcp_pkg::PH_DONE;
            r.cls   = term ? nlcp_pkg::CL_REAL : nlcp_pkg::CL_INVALID;
          end
        end
        default: begin
        end
      endcase
    end
    if (c == nlcp_pkg::CH_NUL) begin
      r.phase = nlcp_pkg::PH_ENDED;
    end
    return r;
  endfunction

  // binary literal tracker: one byte
  function automatic nlcp_pkg::bin_phase_t bin_step(input nlcp_pkg::bin_phase_t b,
                                                   input logic [7:0] c);
    nlcp_pkg::bin_phase_t r;
    r = b;
    if (b == nlcp_pkg::BP_START || b == nlcp_pkg::BP_DIGITS) begin
      if (c == nlcp_pkg::CH_DIG0 || c == nlcp_pkg::CH_DIG1) begin
        r = nlcp_pkg::BP_DIGITS;
      end else if ((c == nlcp_pkg::CH_B_LO || c == nlcp_pkg::CH_B_UP) &&
                   b == nlcp_pkg::BP_DIGITS) begin
        r = nlcp_pkg::BP_YES;
      end else begin
        r = nlcp_pkg::BP_FAIL;
      end
    end
    return r;
  endfunction

  // state registers
  nlcp_pkg::scan_state_t   scan;
  nlcp_pkg::bin_phase_t    bin_phase;
  nlcp_pkg::dec_phase_t    dec_phase;
  logic                    negative_sign;
  logic [VALUE_WIDTH-1:0]  dec_acc;
  logic [VALUE_WIDTH-1:0]  hex_acc;
  logic [VALUE_WIDTH-1:0]  bin_acc;

  nlcp_pkg::scan_state_t   scan_next;
  nlcp_pkg::scan_state_t   scan_final;
  nlcp_pkg::bin_phase_t    bin_phase_next;
  nlcp_pkg::bin_phase_t    bin_phase_final;
  nlcp_pkg::dec_phase_t    dec_phase_next;
  logic                    negative_sign_next;
  logic [VALUE_WIDTH-1:0]  dec_acc_next;
  logic [VALUE_WIDTH-1:0]  hex_acc_next;
  logic [VALUE_WIDTH-1:0]  bin_acc_next;

  logic                    active;
  logic                    ws;
  logic                    dec_upd;
  logic                    hex_upd;
  logic                    bin_upd;
  logic [VALUE_WIDTH-1:0]  dec_times10;
  nlcp_pkg::class_t        cls;
  logic                    val_ok;
  logic [VALUE_WIDTH-1:0]  val;
  logic [VALUE_WIDTH+nlcp_pkg::RESULT_WIDTH-1:0] val_ext;

  // the text stops being scanned once its zero byte is seen
  assign active = (scan.phase != nlcp_pkg::PH_ENDED);
  assign ws     = (ch == nlcp_pkg::CH_SPACE) ||
                  ((ch >= nlcp_pkg::CH_TAB) && (ch <= nlcp_pkg::CH_CR));

  // accumulator update enables
  assign hex_upd = active && is_hex(ch) &&
                   (scan.phase == nlcp_pkg::PH_HEX0 || scan.phase == nlcp_pkg::PH_HEX);
  assign bin_upd = active && (ch == nlcp_pkg::CH_DIG0 || ch == nlcp_pkg::CH_DIG1) &&
                   (bin_phase == nlcp_pkg::BP_START || bin_phase == nlcp_pkg::BP_DIGITS);
  assign dec_upd = active && is_dec(ch) && (dec_phase != nlcp_pkg::DP_STOP);

  // constant-factor accumulators: x16, x2 by shift, x10 as 8x + 2x
  assign dec_times10  = {dec_acc[VALUE_WIDTH-4:0], 3'b000} + {dec_acc[VALUE_WIDTH-2:0], 1'b0};
  assign dec_acc_next = dec_upd ? VALUE_WIDTH'(dec_times10 + VALUE_WIDTH'(ch[3:0])) : dec_acc;
  assign hex_acc_next = hex_upd ? {hex_acc[VALUE_WIDTH-5:0], hex_val(ch)} : hex_acc;
  assign bin_acc_next = bin_upd ? {bin_acc[VALUE_WIDTH-2:0], ch[0]} : bin_acc;

  // decimal parser phase and sign
  always_comb begin
    dec_phase_next     = dec_phase;
    negative_sign_next = negative_sign;
    if (active) begin
      unique case (dec_phase)
        nlcp_pkg::DP_WS: begin
          if (ws) begin
            dec_phase_next = nlcp_pkg::DP_WS;
          end else if (ch == nlcp_pkg::CH_PLUS || ch == nlcp_pkg::CH_MINUS) begin
            negative_sign_next = (ch == nlcp_pkg::CH_MINUS);
            dec_phase_next     = nlcp_pkg::DP_SIGN;
          end else if (is_dec(ch)) begin
            dec_phase_next = nlcp_pkg::DP_DIGITS;
          end else begin
            dec_phase_next = nlcp_pkg::DP_STOP;
          end
        end
        nlcp_pkg::DP_SIGN, nlcp_pkg::DP_DIGITS: begin
          dec_phase_next = is_dec(ch) ? nlcp_pkg::DP_DIGITS : nlcp_pkg::DP_STOP;
        end
        default: begin
        end
      endcase
    end
  end

  // scanner and binary tracker for this byte
  always_comb begin
    scan_next      = scan;
    bin_phase_next = bin_phase;
    if (active) begin
      scan_next      = scan_step(scan, ch);
      bin_phase_next = bin_step(bin_phase, ch);
    end
  end

  // closing the text: an implicit zero byte unless one was already seen
  always_comb begin
    scan_final      = scan_next;
    bin_phase_final = bin_phase_next;
    if (scan_next.phase != nlcp_pkg::PH_ENDED) begin
      scan_final      = scan_step(scan_next, nlcp_pkg::CH_NUL);
      bin_phase_final = bin_step(bin_phase_next, nlcp_pkg::CH_NUL);
    end
  end

  // result class and value
  always_comb begin
    cls    = scan_final.cls;
    val_ok = 1'b0;
    val    = '0;
    if (cls == nlcp_pkg::CL_INVALID && bin_phase_final == nlcp_pkg::BP_YES) begin
      cls = nlcp_pkg::CL_BIN;
    end
    case (cls)
      nlcp_pkg::CL_HEX: begin
        val_ok = 1'b1;
        val    = hex_acc_next;
      end
      nlcp_pkg::CL_INT: begin
        val_ok = 1'b1;
        val    = negative_sign_next ? VALUE_WIDTH'('0 - dec_acc_next) : dec_acc_next;
      end
      nlcp_pkg::CL_BIN: begin
        val_ok = 1'b1;
        val    = bin_acc_next;
      end
      default: begin
      end
    endcase
  end

  assign val_ext             = {{nlcp_pkg::RESULT_WIDTH{1'b0}}, val};
  assign result.number_class = cls;
  assign result.value_valid  = val_ok;
  assign result.value        = val_ext[nlcp_pkg::RESULT_WIDTH-1:0];

  // state update; the last byte returns everything to the start of a text
  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      scan.phase    <= nlcp_pkg::PH_START;
      scan.cls      <= nlcp_pkg::CL_INVALID;
      bin_phase     <= nlcp_pkg::BP_START;
      dec_phase     <= nlcp_pkg::DP_WS;
      negative_sign <= 1'b0;
      dec_acc       <= '0;
      hex_acc       <= '0;
      bin_acc       <= '0;
    end else if (take) begin
      scan          <= scan_next;
      bin_phase     <= bin_phase_next;
      dec_phase     <= dec_phase_next;
      negative_sign <= negative_sign_next;
      dec_acc       <= dec_acc_next;
      hex_acc       <= hex_acc_next;
      bin_acc       <= bin_acc_next;
    end
  end

endmodule

// File: rtl/numeric_literal_classify_parse.sv
// Numeric literal classifier: takes one text byte per item on the text channel and,
// on the byte flagged last, delivers one result with the literal's class (invalid,
// hexadecimal, decimal integer, decimal real, binary) and, for hexadecimal, decimal
// integer and binary, its integer value wrapped to VALUE_WIDTH bits and then shown
// in 32 bits. A zero byte or a space terminates the literal; bytes after a zero byte
// are ignored until the last flag. A new byte is accepted whenever the text channel is
// ready; the scanner state and the three accumulators update in the cycle the byte is
// accepted, and the result is registered, so it appears on the result channel the cycle
// after the last byte unless an earlier result is still waiting there.
// A two-entry output buffer lets the text channel keep streaming while a result waits;
// the text channel stalls only when both entries hold undelivered results.
`timescale 1ns / 1ps

module numeric_literal_classify_parse #(
  parameter int VALUE_WIDTH = nlcp_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  nlcp_text_if.sink     text,
  nlcp_result_if.source result
);

  logic                   take;
  logic                   push;
  nlcp_pkg::scan_result_t res_new;

  // output buffer: main register and skid register
  nlcp_pkg::scan_result_t main_res;
  nlcp_pkg::scan_result_t skid_res;
  logic                   main_valid;
  logic                   skid_valid;
  logic                   main_free;

  assign text.ready = !skid_valid;
  assign take       = text.valid && text.ready;
  assign push       = take && text.last;
  assign main_free  = !main_valid || result.ready;

  // per-byte scanner
  nlcp_scan #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .ch     (text.ch),
    .last   (text.last),
    .result (res_new)
  );

  // buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_res <= skid_valid ? skid_res : res_new;
    end else if (push) begin
      skid_res <= res_new;
    end
  end

  assign result.valid        = main_valid;
  assign result.number_class = main_res.number_class;
  assign result.value_valid  = main_res.value_valid;
  assign result.value        = main_res.value;

`ifndef SYNTH
  // the skid entry only fills behind a waiting main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry valid while main entry empty");

  // after the last byte of a text, the result channel always holds a valid result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready && text.last) |=> result.valid)
    else $error("no result after last byte");

  // a value is only offered for the integer classes, and is zero otherwise
  a_value_class: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.value_valid ?
      (result.number_class == nlcp_pkg::CL_HEX || result.number_class == nlcp_pkg::CL_INT ||
       result.number_class == nlcp_pkg::CL_BIN) : (result.value == '0)))
    else $error("value flag does not match class");
`endif

endmodule

// File: tb/tb_top.sv
// testbench for the numeric literal classifier: directed texts, then random texts
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int N_DIRECTED   = 27;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_SQUARE = 3;

  // shapes of well-formed random texts
  localparam int SHAPE_HEX  = 0;
  localparam int SHAPE_DEC  = 1;
  localparam int SHAPE_REAL = 2;
  localparam int SHAPE_BIN  = 3;

  // one row of the directed table; want is only used where typed is set
  typedef struct packed {
    logic [7:0]             ch;
    logic                   last;
    logic                   typed;
    nlcp_pkg::scan_result_t want;
  } text_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nlcp_text_if   text_if ();
  nlcp_result_if result_if ();

  numeric_literal_classify_parse uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .result (result_if)
  );

  always #1 clk = ~clk;

  // mirror of the literal scanner
  nlcp_pkg::scan_phase_t  lit_phase;
  nlcp_pkg::class_t       lit_class;
  nlcp_pkg::bin_phase_t   bin_phase;
  nlcp_pkg::dec_phase_t   dec_phase;
  logic                   dec_negative;
  logic [31:0]            dec_acc;
  logic [31:0]            hex_acc;
  logic [31:0]            bin_acc;

  nlcp_pkg::scan_result_t literal_results_q[$];
  int                     mismatches = 0;
  int                     bytes_sent = 0;
  int                     burst_left = 0;

  function automatic logic dec_char(input logic [7:0] c);
    return c >= nlcp_pkg::CH_DIG0 && c <= nlcp_pkg::CH_DIG9;
  endfunction

  function automatic int hex_digit_value(input logic [7:0] c);
    if (dec_char(c)) return int'(c - nlcp_pkg::CH_DIG0);
    if (c >= nlcp_pkg::CH_A_LO && c <= nlcp_pkg::CH_F_LO) return int'(c - nlcp_pkg::CH_A_LO) + 10;
    if (c >= nlcp_pkg::CH_A_UP && c <= nlcp_pkg::CH_F_UP) return int'(c - nlcp_pkg::CH_A_UP) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_digit(input int hi);
    return nlcp_pkg::CH_DIG0 + 8'($urandom_range(0, hi));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return nlcp_pkg::CH_DIG0 + 8'(v);
    if ($urandom_range(0, 1)) return nlcp_pkg::CH_A_UP + 8'(v - 10);
    return nlcp_pkg::CH_A_LO + 8'(v - 10);
  endfunction

  task automatic clear_literal();
    lit_phase    = nlcp_pkg::PH_START;
    lit_class    = nlcp_pkg::CL_INVALID;
    bin_phase    = nlcp_pkg::BP_START;
    dec_phase    = nlcp_pkg::DP_WS;
    dec_negative = 1'b0;
    dec_acc      = '0;
    hex_acc      = '0;
    bin_acc      = '0;
  endtask

  task automatic settle_class(input logic ok, input nlcp_pkg::class_t good);
    if (ok) lit_class = good;
    else lit_class = nlcp_pkg::CL_INVALID;
    lit_phase = nlcp_pkg::PH_DONE;
  endtask

  // advance all three trackers by one character
  task automatic scan_char(input logic [7:0] c);
    logic                  term;
    logic                  ws;
    logic                  taken;
    logic                  dec_step;
    nlcp_pkg::scan_phase_t p;
    int                    h;
    term  = (c == nlcp_pkg::CH_NUL) || (c == nlcp_pkg::CH_SPACE);
    ws    = (c == nlcp_pkg::CH_SPACE) || (c >= nlcp_pkg::CH_TAB && c <= nlcp_pkg::CH_CR);
    p     = lit_phase;
    h     = hex_digit_value(c);
    taken = 1'b0;

    // leading minus, leading zero and the hex prefix
    if (p == nlcp_pkg::PH_START) begin
      if (c == nlcp_pkg::CH_MINUS) begin
        lit_phase = nlcp_pkg::PH_INT;
        taken = 1'b1;
      end else if (c == nlcp_pkg::CH_DIG0) begin
        lit_phase = nlcp_pkg::PH_ZERO;
        taken = 1'b1;
      end else begin
        p = nlcp_pkg::PH_INT;
      end
    end else if (p == nlcp_pkg::PH_ZERO) begin
      if (c == nlcp_pkg::CH_X_LO || c == nlcp_pkg::CH_X_UP) begin
        lit_phase = nlcp_pkg::PH_HEX0;
        taken = 1'b1;
      end else begin
        p = nlcp_pkg::PH_INT;
      end
    end

    // class scanner
    if (!taken) begin
      case (p)
        nlcp_pkg::PH_INT: begin
          if (dec_char(c)) lit_phase = nlcp_pkg::PH_INT;
          else if (c == nlcp_pkg::CH_DOT) lit_phase = nlcp_pkg::PH_FRAC;
          else if (c == nlcp_pkg::CH_E_LO) lit_phase = nlcp_pkg::PH_EXP0;
          else settle_class(term, nlcp_pkg::CL_INT);
        end
        nlcp_pkg::PH_HEX0, nlcp_pkg::PH_HEX: begin
          if (h >= 0) begin
            hex_acc = (hex_acc << 4) | 32'(h);
            lit_phase = nlcp_pkg::PH_HEX;
          end else begin
            settle_class(term && p == nlcp_pkg::PH_HEX, nlcp_pkg::CL_HEX);
          end
        end
        nlcp_pkg::PH_FRAC: begin
          if (dec_char(c)) lit_phase = nlcp_pkg::PH_FRAC;
          else if (c == nlcp_pkg::CH_E_LO) lit_phase = nlcp_pkg::PH_EXP0;
          else settle_class(term, nlcp_pkg::CL_REAL);
        end
        nlcp_pkg::PH_EXP0: begin
          if (c == nlcp_pkg::CH_PLUS || c == nlcp_pkg::CH_MINUS || dec_char(c))
            lit_phase = nlcp_pkg::PH_EXP;
          else settle_class(term, nlcp_pkg::CL_REAL);
        end
        nlcp_pkg::PH_EXP: begin
          if (dec_char(c)) lit_phase = nlcp_pkg::PH_EXP;
          else settle_class(term, nlcp_pkg::CL_REAL);
        end
        default: ;
      endcase
    end

    // binary literal: 0/1 digits then b or B
    if (bin_phase == nlcp_pkg::BP_START || bin_phase == nlcp_pkg::BP_DIGITS) begin
      if (c == nlcp_pkg::CH_DIG0 || c == nlcp_pkg::CH_DIG1) begin
        bin_acc = {bin_acc[30:0], c[0]};
        bin_phase = nlcp_pkg::BP_DIGITS;
      end else if ((c == nlcp_pkg::CH_B_LO || c == nlcp_pkg::CH_B_UP) &&
                   bin_phase == nlcp_pkg::BP_DIGITS) begin
        bin_phase = nlcp_pkg::BP_YES;
      end else begin
        bin_phase = nlcp_pkg::BP_FAIL;
      end
    end

    // decimal value: white space, one sign, then digits
    dec_step = (dec_phase == nlcp_pkg::DP_SIGN) || (dec_phase == nlcp_pkg::DP_DIGITS);
    if (dec_phase == nlcp_pkg::DP_WS && !ws) begin
      if (c == nlcp_pkg::CH_PLUS || c == nlcp_pkg::CH_MINUS) begin
        dec_negative = (c == nlcp_pkg::CH_MINUS);
        dec_phase = nlcp_pkg::DP_SIGN;
      end else begin
        dec_step = 1'b1;
      end
    end
    if (dec_step) begin
      if (dec_char(c)) begin
        dec_acc = dec_acc * 32'd10 + 32'(c - nlcp_pkg::CH_DIG0);
        dec_phase = nlcp_pkg::DP_DIGITS;
      end else begin
        dec_phase = nlcp_pkg::DP_STOP;
      end
    end

    if (c == nlcp_pkg::CH_NUL) lit_phase = nlcp_pkg::PH_ENDED;
  endtask

  // offer one byte, wait for the handshake, then predict
  task automatic send_text_byte(input logic [7:0] c, input logic l, input logic typed,
                                input nlcp_pkg::scan_result_t want);
    nlcp_pkg::scan_result_t got;
    nlcp_pkg::class_t       cls;
    // gap between bursts
    if (burst_left == 0) begin
      text_if.valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3))
        @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    text_if.valid = 1'b1;
    text_if.ch    = c;
    text_if.last  = l;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    bytes_sent++;
    burst_left--;

    // the byte is in: update the mirror, close the text on last
    if (lit_phase != nlcp_pkg::PH_ENDED) scan_char(c);
    if (l) begin
      if (lit_phase != nlcp_pkg::PH_ENDED) scan_char(nlcp_pkg::CH_NUL);
      cls = lit_class;
      if (cls == nlcp_pkg::CL_INVALID && bin_phase == nlcp_pkg::BP_YES) cls = nlcp_pkg::CL_BIN;
      got.number_class = cls;
      got.value_valid  = 1'b0;
      got.value        = '0;
      case (cls)
        nlcp_pkg::CL_HEX: begin
          got.value_valid = 1'b1;
          got.value = hex_acc;
        end
        nlcp_pkg::CL_INT: begin
          got.value_valid = 1'b1;
          got.value = dec_negative ? 32'd0 - dec_acc : dec_acc;
        end
        nlcp_pkg::CL_BIN: begin
          got.value_valid = 1'b1;
          got.value = bin_acc;
        end
        default: ;
      endcase
      literal_results_q = {literal_results_q, (typed ? want : got)};
      clear_literal();
    end
    @(negedge clk);
  endtask

  // hold the sender until every pending result is out
  task automatic wait_results_drained();
    text_if.valid = 1'b0;
    while (literal_results_q.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    nlcp_pkg::scan_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (literal_results_q.size() == 0) begin
        $error("unexpected result: class %0d value %h", result_if.number_class,
               result_if.value);
        mismatches++;
      end else begin
        want = literal_results_q.pop_front();
        if (result_if.number_class !== want.number_class) begin
          $error("number_class: expected %0d, got %0d", want.number_class,
                 result_if.number_class);
          mismatches++;
        end
        if (result_if.value_valid !== want.value_valid) begin
          $error("value_valid: expected %0d, got %0d", want.value_valid,
                 result_if.value_valid);
          mismatches++;
        end
        if (result_if.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, result_if.value);
          mismatches++;
        end
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int rcv_cycle;
    int mode;
    result_if.ready = 1'b0;
    rcv_cycle = 0;
    mode = RX_OPEN;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rcv_cycle % 50 == 0) mode = $urandom_range(RX_OPEN, RX_SQUARE);
      if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_CYCLES) begin
        result_if.ready = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   result_if.ready = 1'b1;
          RX_COIN:   result_if.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: result_if.ready = ($urandom_range(0, 3) == 0);
          default:   result_if.ready = (rcv_cycle % 8) < 4;
        endcase
      end
      rcv_cycle++;
      @(negedge clk);
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // stimulus
  initial begin : text_source
    text_row_t  directed [N_DIRECTED];
    logic [7:0] txt[$];
    int         kind;
    int         shape;
    int         n;
    logic       drained_mid;

    text_if.valid = 1'b0;
    text_if.ch    = nlcp_pkg::CH_NUL;
    text_if.last  = 1'b0;
    drained_mid   = 1'b0;
    clear_literal();

    directed = '{
      // lone zero digit
      '{nlcp_pkg::CH_DIG0,  1'b1, 1'b1, '{nlcp_pkg::CL_INT, 1'b1, 32'd0}},
      // hex, mixed case
      '{nlcp_pkg::CH_DIG0,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_X_LO,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_DIG1,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_F_UP,  1'b1, 1'b1, '{nlcp_pkg::CL_HEX, 1'b1, 32'h0000_001F}},
      // negative decimal
      '{nlcp_pkg::CH_MINUS, 1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_DIG1,  1'b0, 1'b0, '0},
      '{"2",                1'b1, 1'b1, '{nlcp_pkg::CL_INT, 1'b1, 32'hFFFF_FFF4}},
      // real with fraction, no value
      '{nlcp_pkg::CH_DIG1,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_DOT,   1'b0, 1'b0, '0},
      '{"5",                1'b1, 1'b1, '{nlcp_pkg::CL_REAL, 1'b0, 32'd0}},
      // binary
      '{nlcp_pkg::CH_DIG1,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_DIG0,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_DIG1,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_B_LO,  1'b1, 1'b1, '{nlcp_pkg::CL_BIN, 1'b1, 32'd5}},
      // zero byte ends the text, the rest is ignored
      '{"7",                1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_NUL,   1'b0, 1'b0, '0},
      '{8'hFF,              1'b1, 1'b1, '{nlcp_pkg::CL_INT, 1'b1, 32'd7}},
      // top byte alone is invalid
      '{8'hFF,              1'b1, 1'b1, '{nlcp_pkg::CL_INVALID, 1'b0, 32'd0}},
      // exponent with sign and no digits
      '{"2",                1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_E_LO,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_MINUS, 1'b1, 1'b0, '0},
      // leading space
      '{nlcp_pkg::CH_SPACE, 1'b0, 1'b0, '0},
      '{"5",                1'b1, 1'b0, '0},
      // hex prefix without digits
      '{nlcp_pkg::CH_DIG0,  1'b0, 1'b0, '0},
      '{nlcp_pkg::CH_X_UP,  1'b1, 1'b1, '{nlcp_pkg::CL_INVALID, 1'b0, 32'd0}},
      // empty text
      '{nlcp_pkg::CH_NUL,   1'b1, 1'b1, '{nlcp_pkg::CL_INT, 1'b1, 32'd0}}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      send_text_byte(directed[i].ch, directed[i].last, directed[i].typed, directed[i].want);
    wait_results_drained();

    // random texts: mostly well-formed, some broken, some noise
    while (bytes_sent < N_DIRECTED + RANDOM_ITEMS) begin
      txt.delete();
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
        shape = $urandom_range(SHAPE_HEX, SHAPE_BIN);
        case (shape)
          SHAPE_HEX: begin
            txt = {txt, nlcp_pkg::CH_DIG0};
            txt = {txt, ($urandom_range(0, 1) ? nlcp_pkg::CH_X_LO : nlcp_pkg::CH_X_UP)};
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
            repeat (n) txt = {txt, rand_hex_char()};
          end
          SHAPE_DEC: begin
            if ($urandom_range(0, 5) == 0)
              repeat ($urandom_range(1, 2))
                txt = {txt, ($urandom_range(0, 1) ? nlcp_pkg::CH_SPACE
                                                  : nlcp_pkg::CH_TAB + 8'($urandom_range(0, 4)))};
            case ($urandom_range(0, 3))
              0: txt = {txt, nlcp_pkg::CH_MINUS};
              1: txt = {txt, nlcp_pkg::CH_PLUS};
              default: ;
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 5);
            repeat (n) txt = {txt, rand_digit(9)};
          end
          SHAPE_REAL: begin
            repeat ($urandom_range(0, 3)) txt = {txt, rand_digit(9)};
            if ($urandom_range(0, 1)) begin
              txt = {txt, nlcp_pkg::CH_DOT};
              repeat ($urandom_range(0, 3)) txt = {txt, rand_digit(9)};
            end
            if ($urandom_range(0, 1)) begin
              txt = {txt, nlcp_pkg::CH_E_LO};
              case ($urandom_range(0, 2))
                0: txt = {txt, nlcp_pkg::CH_MINUS};
                1: txt = {txt, nlcp_pkg::CH_PLUS};
                default: ;
              endcase
              repeat ($urandom_range(0, 3)) txt = {txt, rand_digit(9)};
            end
          end
          default: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 36) : $urandom_range(1, 6);
            repeat (n) txt = {txt, rand_digit(1)};
            txt = {txt, ($urandom_range(0, 1) ? nlcp_pkg::CH_B_LO : nlcp_pkg::CH_B_UP)};
            repeat ($urandom_range(0, 2)) txt = {txt, 8'($urandom_range(0, 255))};
          end
        endcase
        // broken text: one byte swapped for any value
        if (kind >= 78 && txt.size() > 0)
          txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 6)) txt = {txt, 8'($urandom_range(0, 255))};
      end

      // terminator, and junk after it
      case ($urandom_range(0, 3))
        0: begin
          txt = {txt, nlcp_pkg::CH_SPACE};
          repeat ($urandom_range(0, 2)) txt = {txt, 8'($urandom_range(0, 255))};
        end
        1: begin
          txt = {txt, nlcp_pkg::CH_NUL};
          repeat ($urandom_range(0, 3)) txt = {txt, 8'($urandom_range(0, 255))};
        end
        default: ;
      endcase
      if (txt.size() == 0) txt = {txt, nlcp_pkg::CH_NUL};

      foreach (txt[i]) send_text_byte(txt[i], i == txt.size() - 1, 1'b0, '0);

      // one pause halfway until everything has come back
      if (!drained_mid && bytes_sent >= N_DIRECTED + RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
